// ===== rtl/rtt_pkg.sv =====
// Shared types and constants for the route template to regex translator.
// Used by the top level, the front end, the descriptor queue and the back end.
package rtt_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_NAME    = 2'd1;
    localparam logic [1:0] KIND_OPEN    = 2'd2;
    localparam logic [1:0] KIND_PATTERN = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BRACE    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    // body of the results one template byte produces
    typedef enum logic [2:0] {
        BODY_NONE    = 3'd0,
        BODY_LIT     = 3'd1,
        BODY_OPEN    = 3'd2,
        BODY_PATOPEN = 3'd3,
        BODY_NAME    = 3'd4,
        BODY_PLAIN   = 3'd5
    } body_t;

    typedef struct packed {
        logic       start;
        body_t      body;
        logic       esc;
        logic [7:0] ch;
        logic [7:0] grp;
        logic [3:0] nb;
        logic       dollar;
        logic       filler;
        logic       last;
        logic [1:0] err;
    } desc_t;

    function automatic logic is_meta(input logic [7:0] c);
        return c == 8'h2F || c == 8'h2E || c == 8'h3F || c == CH_LPAREN ||
               c == CH_RPAREN || c == 8'h5B || c == 8'h5D || c == 8'h2A ||
               c == 8'h2B || c == CH_CARET || c == CH_BSLASH;
    endfunction

    // "([^\/]+)"
    function automatic logic [7:0] plain_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_LPAREN;
            3'd1:    c = 8'h5B;
            3'd2:    c = CH_CARET;
            3'd3:    c = CH_BSLASH;
            3'd4:    c = 8'h2F;
            3'd5:    c = 8'h5D;
            3'd6:    c = 8'h2B;
            3'd7:    c = CH_RPAREN;
            default: c = CH_RPAREN;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/rtt_if.sv =====
// Valid/ready channel interfaces for template bytes in and regex results out.
// Depends on nothing but the beat widths fixed here.
interface rtt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink   (input valid, input ch, input last_char, output ready);
endinterface

interface rtt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_char;
    logic [7:0] group_number;
    logic [1:0] error_code;
    logic       end_of_route;

    modport source (output valid, output out_kind, output out_char,
                    output group_number, output error_code, output end_of_route,
                    input ready);
    modport sink   (input valid, input out_kind, input out_char,
                    input group_number, input error_code, input end_of_route,
                    output ready);
endinterface

// ===== rtl/route_template_to_regex.sv =====
// Top level of the route template to regex translator.
// Depends on rtt_pkg, rtt_if, rtt_front, rtt_fifo and rtt_back.
//
//  channel  dir  beat
//  tmpl     in   ch[7:0], last_char
//  regex    out  out_kind[1:0], out_char[7:0], group_number[7:0],
//                error_code[1:0], end_of_route
//  cfg      in   cfg_wr_en, cfg_wr_data (end anchor off)
//
// A template byte is taken while the queue has room; it gives 0 to 10 result
// beats (a filler beat when the final byte would give none), issued by the
// back end at one beat per cycle when not stalled, so sustained throughput is
// set by the back end's beat counter. The four-entry descriptor queue lets the
// front keep taking bytes while results stall. Reset clears all parse state.
module route_template_to_regex
#(
    parameter int MAX_BRACE_DEPTH = 15,
    parameter int MAX_GROUPS      = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    rtt_in_if.sink     tmpl,
    rtt_out_if.source  regex
);
    import rtt_pkg::*;

    logic  open_end_reg;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_not_empty;
    desc_t q_desc;
    desc_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_end_reg <= 1'b0;
        else if (cfg_wr_en)
            open_end_reg <= cfg_wr_data;
    end

    rtt_front #(
        .MAX_BRACE_DEPTH (MAX_BRACE_DEPTH),
        .MAX_GROUPS      (MAX_GROUPS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .open_end    (open_end_reg),
        .tmpl        (tmpl),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_desc      (q_desc)
    );

    rtt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_desc (q_head)
    );

    rtt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .regex       (regex)
    );

endmodule

// ===== rtl/rtt_fifo.sv =====
// Short descriptor queue between front end and back end.
// Depends on rtt_pkg for desc_t and the queue depth.
module rtt_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rtt_pkg::desc_t push_desc,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output rtt_pkg::desc_t head_desc
);
    import rtt_pkg::*;

    desc_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full      = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_desc = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== rtl/rtt_front.sv =====
// Front end: takes template bytes, keeps the parse state, queues a descriptor.
// Depends on rtt_pkg and rtt_in_if.
module rtt_front
#(
    parameter int MAX_BRACE_DEPTH = 15,
    parameter int MAX_GROUPS      = 255
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           open_end,
    rtt_in_if.sink         tmpl,
    input  logic           q_full,
    output logic           q_push,
    output rtt_pkg::desc_t q_desc
);
    import rtt_pkg::*;

    localparam int DW = $clog2(MAX_BRACE_DEPTH + 1);
    localparam int GW = $clog2(MAX_GROUPS + 1);

    logic          at_start_reg, at_start_next;
    logic          in_cap_reg, in_cap_next;
    logic          in_pat_reg, in_pat_next;
    logic          esc_reg, esc_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [GW-1:0] gcount_reg, gcount_next;
    logic [GW-1:0] capg_reg, capg_next;
    logic [1:0]    err_reg, err_next;

    logic          accept;
    logic [7:0]    c;
    logic [3:0]    total;
    desc_t         d;

    assign tmpl.ready = !q_full;
    assign accept     = tmpl.valid && tmpl.ready;
    assign c          = tmpl.ch;

    always_comb
    begin
        at_start_next = 1'b0;
        in_cap_next   = in_cap_reg;
        in_pat_next   = in_pat_reg;
        esc_next      = esc_reg;
        depth_next    = depth_reg;
        gcount_next   = gcount_reg;
        capg_next     = capg_reg;
        err_next      = err_reg;

        d        = '0;
        d.start  = at_start_reg;
        d.body   = BODY_NONE;
        d.ch     = c;
        d.last   = tmpl.last_char;

        if (!in_cap_reg)
        begin
            if (esc_reg)
            begin
                esc_next = 1'b0;
                d.body   = BODY_LIT;
                d.esc    = is_meta(c) || c == CH_LBRACE || c == CH_RBRACE;
                d.nb     = d.esc ? 4'd2 : 4'd1;
            end
            else if (c == CH_BSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (c == CH_LBRACE)
            begin
                if (gcount_reg >= GW'(MAX_GROUPS))
                begin
                    if (err_next == ERR_NONE)
                        err_next = ERR_OVERFLOW;
                end
                else
                begin
                    gcount_next = gcount_reg + 1'b1;
                end
                capg_next   = gcount_next;
                in_cap_next = 1'b1;
                in_pat_next = 1'b0;
                depth_next  = '0;
                d.body      = BODY_OPEN;
                d.grp       = 8'(gcount_next);
                d.nb        = 4'd1;
            end
            else if (c == CH_RBRACE)
            begin
                if (err_next == ERR_NONE)
                    err_next = ERR_BRACE;
            end
            else
            begin
                d.body = BODY_LIT;
                d.esc  = is_meta(c);
                d.nb   = d.esc ? 4'd2 : 4'd1;
            end
        end
        else if (!in_pat_reg)
        begin
            if (c == CH_COLON)
            begin
                in_pat_next = 1'b1;
                d.body      = BODY_PATOPEN;
                d.grp       = 8'(capg_reg);
                d.nb        = 4'd2;
            end
            else if (c == CH_RBRACE)
            begin
                in_cap_next = 1'b0;
                d.body      = BODY_PLAIN;
                d.nb        = 4'd8;
            end
            else
            begin
                d.body = BODY_NAME;
                d.nb   = 4'd1;
            end
        end
        else
        begin
            d.body = BODY_LIT;
            d.nb   = 4'd1;
            if (esc_reg)
            begin
                esc_next = 1'b0;
            end
            else if (c == CH_BSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (c == CH_LBRACE)
            begin
                if (depth_reg >= DW'(MAX_BRACE_DEPTH))
                begin
                    if (err_next == ERR_NONE)
                        err_next = ERR_OVERFLOW;
                end
                else
                begin
                    depth_next = depth_reg + 1'b1;
                end
            end
            else if (c == CH_RBRACE)
            begin
                if (depth_reg == '0)
                begin
                    d.ch        = CH_RPAREN;
                    in_cap_next = 1'b0;
                    in_pat_next = 1'b0;
                end
                else
                begin
                    depth_next = depth_reg - 1'b1;
                end
            end
            else if (c == CH_LPAREN)
            begin
                if (gcount_reg >= GW'(MAX_GROUPS))
                begin
                    if (err_next == ERR_NONE)
                        err_next = ERR_OVERFLOW;
                end
                else
                begin
                    gcount_next = gcount_reg + 1'b1;
                end
            end
        end

        if (tmpl.last_char)
        begin
            if (in_cap_next && err_next == ERR_NONE)
                err_next = ERR_BRACE;
            d.dollar = !open_end;
        end
        total    = d.nb + {3'b0, d.start} + {3'b0, d.dollar};
        d.filler = tmpl.last_char && total == '0;
        d.err    = err_next;

        if (tmpl.last_char)
        begin
            at_start_next = 1'b1;
            in_cap_next   = 1'b0;
            in_pat_next   = 1'b0;
            esc_next      = 1'b0;
            depth_next    = '0;
            gcount_next   = '0;
            capg_next     = '0;
            err_next      = ERR_NONE;
        end
    end

    assign q_desc = d;
    assign q_push = accept && (total != '0 || tmpl.last_char);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
            in_cap_reg   <= 1'b0;
            in_pat_reg   <= 1'b0;
            esc_reg      <= 1'b0;
            depth_reg    <= '0;
            gcount_reg   <= '0;
            capg_reg     <= '0;
            err_reg      <= ERR_NONE;
        end
        else if (accept)
        begin
            at_start_reg <= at_start_next;
            in_cap_reg   <= in_cap_next;
            in_pat_reg   <= in_pat_next;
            esc_reg      <= esc_next;
            depth_reg    <= depth_next;
            gcount_reg   <= gcount_next;
            capg_reg     <= capg_next;
            err_reg      <= err_next;
        end
    end

endmodule

// ===== rtl/rtt_back.sv =====
// Back end: expands queued descriptors into result beats, one per cycle
// while the output is not stalled. Depends on rtt_pkg and rtt_out_if.
module rtt_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_not_empty,
    input  rtt_pkg::desc_t q_head,
    output logic           q_pop,
    rtt_out_if.source      regex
);
    import rtt_pkg::*;

    desc_t      cur_reg;
    logic       cur_valid_reg;
    logic [3:0] step_reg;

    logic       o_valid_reg;
    logic [1:0] o_kind_reg, o_kind_next;
    logic [7:0] o_char_reg, o_char_next;
    logic [7:0] o_grp_reg, o_grp_next;
    logic [1:0] o_err_reg;
    logic       o_eor_reg, o_eor_next;

    logic [3:0] total;
    logic [3:0] j;
    logic       adv;
    logic       last_step;

    assign total     = cur_reg.nb + {3'b0, cur_reg.start} + {3'b0, cur_reg.dollar}
                     + {3'b0, cur_reg.filler};
    assign j         = step_reg - {3'b0, cur_reg.start};
    assign last_step = step_reg == total - 1'b1;
    assign adv       = cur_valid_reg && (!o_valid_reg || regex.ready);
    assign q_pop     = q_not_empty && (!cur_valid_reg || (adv && last_step));

    always_comb
    begin
        o_kind_next = KIND_CHAR;
        o_char_next = 8'h00;
        o_grp_next  = 8'h00;
        o_eor_next  = cur_reg.last && last_step;
        if (cur_reg.start && step_reg == '0)
        begin
            o_char_next = CH_CARET;
        end
        else if (j < cur_reg.nb)
        begin
            case (cur_reg.body)
                BODY_LIT:
                begin
                    o_char_next = (cur_reg.esc && j == '0) ? CH_BSLASH : cur_reg.ch;
                end
                BODY_OPEN:
                begin
                    o_kind_next = KIND_OPEN;
                    o_grp_next  = cur_reg.grp;
                end
                BODY_PATOPEN:
                begin
                    if (j == '0)
                    begin
                        o_kind_next = KIND_PATTERN;
                        o_grp_next  = cur_reg.grp;
                    end
                    else
                    begin
                        o_char_next = CH_LPAREN;
                    end
                end
                BODY_NAME:
                begin
                    o_kind_next = KIND_NAME;
                    o_char_next = cur_reg.ch;
                end
                BODY_PLAIN:
                begin
                    o_char_next = plain_char(j[2:0]);
                end
                default:
                begin
                    o_char_next = 8'h00;
                end
            endcase
        end
        else if (cur_reg.dollar && j == cur_reg.nb)
        begin
            o_char_next = CH_DOLLAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            o_valid_reg   <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                step_reg      <= '0;
            end
            else if (adv)
            begin
                if (last_step)
                begin
                    cur_valid_reg <= 1'b0;
                    step_reg      <= '0;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end

            if (adv)
                o_valid_reg <= 1'b1;
            else if (regex.ready)
                o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_head;
        if (adv)
        begin
            o_kind_reg <= o_kind_next;
            o_char_reg <= o_char_next;
            o_grp_reg  <= o_grp_next;
            o_err_reg  <= cur_reg.err;
            o_eor_reg  <= o_eor_next;
        end
    end

    assign regex.valid        = o_valid_reg;
    assign regex.out_kind     = o_kind_reg;
    assign regex.out_char     = o_char_reg;
    assign regex.group_number = o_grp_reg;
    assign regex.error_code   = o_err_reg;
    assign regex.end_of_route = o_eor_reg;

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> step_reg < total)
        else $error("step beyond descriptor length");

    a_no_lost_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && !regex.ready) |=> o_valid_reg)
        else $error("pending beat dropped under stall");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> (o_err_reg == ERR_NONE || o_err_reg == ERR_BRACE ||
                         o_err_reg == ERR_OVERFLOW))
        else $error("illegal error code on output");

endmodule
